### sv/tos_pkg.sv
package tos_pkg;

    // Field widths of the frame and result words
    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int Q_BITS     = FRAC_BITS + 1;
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int DIV_BITS   = AREA_BITS + 1;
    localparam int TOTAL_BITS = COUNT_BITS + FRAC_BITS + 1;

    localparam logic [Q_BITS-1:0]     ONE_Q        = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [Q_BITS-1:0]     THRESH_RESET = ONE_Q >> 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = {COUNT_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX    = {TOTAL_BITS{1'b1}};

    typedef struct packed {
        logic [COORD_BITS-1:0] truth_x;
        logic [COORD_BITS-1:0] truth_y;
        logic [COORD_BITS-1:0] truth_w;
        logic [COORD_BITS-1:0] truth_h;
        logic                  has_output;
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [COORD_BITS-1:0] out_w;
        logic [COORD_BITS-1:0] out_h;
        logic                  run_end;
    } t_in_word;

    typedef struct packed {
        logic [Q_BITS-1:0]     overlap;
        logic                  hit;
        logic [COUNT_BITS-1:0] frames_seen;
        logic [COUNT_BITS-1:0] hits_seen;
        logic                  run_done;
        logic [Q_BITS-1:0]     hit_score;
        logic [Q_BITS-1:0]     mean_overlap;
    } t_out_word;

    typedef struct packed {
        logic                  start;
        logic [COORD_BITS-1:0] a;
        logic [COORD_BITS-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                 done;
        logic [AREA_BITS-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] num_hi;
        logic [Q_BITS-1:0]   num_lo;
        logic [DIV_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [Q_BITS-1:0] quot;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPAN,
        S_MUL,
        S_UNION,
        S_IOU_GO,
        S_IOU,
        S_TALLY,
        S_SCORE_GO,
        S_SCORE,
        S_MEAN_GO,
        S_MEAN,
        S_WAIT
    } t_state;

endpackage

### sv/tos_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle
module tos_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tos_pkg::t_mul_req i_req,
    output tos_pkg::t_mul_rsp o_rsp
);

    localparam int CNT_W = $clog2(tos_pkg::COORD_BITS);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [CNT_W-1:0]               r_cnt, n_cnt;
    logic [tos_pkg::AREA_BITS-1:0]  r_acc, n_acc;
    logic [tos_pkg::AREA_BITS-1:0]  r_mcand, n_mcand;
    logic [tos_pkg::COORD_BITS-1:0] r_mplier, n_mplier;

    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_cnt    = r_cnt;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        if (i_req.start) begin
            n_busy   = 1'b1;
            n_cnt    = '0;
            n_acc    = '0;
            n_mcand  = {{(tos_pkg::AREA_BITS - tos_pkg::COORD_BITS){1'b0}}, i_req.a};
            n_mplier = i_req.b;
        end else if (r_busy) begin
            if (r_mplier[0]) begin
                n_acc = r_acc + r_mcand;
            end
            n_mcand  = {r_mcand[tos_pkg::AREA_BITS-2:0], 1'b0};
            n_mplier = {1'b0, r_mplier[tos_pkg::COORD_BITS-1:1]};
            n_cnt    = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(tos_pkg::COORD_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = r_acc;

endmodule

### sv/tos_div.sv
// Restoring divider, one quotient bit per cycle; quotient capped at one
module tos_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tos_pkg::t_div_req i_req,
    output tos_pkg::t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(tos_pkg::Q_BITS);

    logic                         r_busy, n_busy;
    logic                         r_done, n_done;
    logic                         r_over, n_over;
    logic [CNT_W-1:0]             r_cnt, n_cnt;
    logic [tos_pkg::DIV_BITS-1:0] r_rem, n_rem;
    logic [tos_pkg::DIV_BITS-1:0] r_den, n_den;
    logic [tos_pkg::Q_BITS-1:0]   r_low, n_low;
    logic [tos_pkg::Q_BITS-1:0]   r_quot, n_quot;
    logic [tos_pkg::DIV_BITS:0]   trial;
    logic [tos_pkg::DIV_BITS:0]   diff;
    logic                         ge;

    assign trial = {r_rem, r_low[tos_pkg::Q_BITS-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_over = r_over;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_low  = r_low;
        n_quot = r_quot;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_req.num_hi;
            n_den  = i_req.den;
            n_low  = i_req.num_lo;
            n_quot = '0;
            // quotient would need more bits than it has: saturate
            n_over = i_req.num_hi >= i_req.den;
        end else if (r_busy) begin
            n_rem  = ge ? diff[tos_pkg::DIV_BITS-1:0] : trial[tos_pkg::DIV_BITS-1:0];
            n_low  = {r_low[tos_pkg::Q_BITS-2:0], 1'b0};
            n_quot = {r_quot[tos_pkg::Q_BITS-2:0], ge};
            n_cnt  = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(tos_pkg::Q_BITS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_over <= n_over;
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_low  <= n_low;
        r_quot <= n_quot;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = (r_over || (r_quot > tos_pkg::ONE_Q)) ? tos_pkg::ONE_Q : r_quot;

endmodule

### sv/tracking_overlap_scorer.sv
// One frame word is worked on at a time; the input stalls while the sequencer is busy.
// The next word is taken once the result is registered and the sequencer is idle; an output
// stall holds the sequencer until the result register is free.
// The work is done by three serial multipliers and one serial divider,
// which runs once per frame and twice more for the run summary.
// Reset (synchronous, active low): tallies cleared, threshold 0.5, no result pending.
module tracking_overlap_scorer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tos_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tos_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_wr_en,
    input  logic [tos_pkg::Q_BITS-1:0]    i_cfg_wr_data
);

    tos_pkg::t_state r_state, n_state;

    // Frame word under work and the run tallies
    tos_pkg::t_in_word                r_in, n_in;
    logic [tos_pkg::Q_BITS-1:0]       r_thr, n_thr;
    logic [tos_pkg::COUNT_BITS-1:0]   r_frames, n_frames;
    logic [tos_pkg::COUNT_BITS-1:0]   r_hits, n_hits;
    logic [tos_pkg::TOTAL_BITS-1:0]   r_total, n_total;

    // Per-frame results
    logic [tos_pkg::DIV_BITS-1:0]     r_uni, n_uni;
    logic [tos_pkg::Q_BITS-1:0]       r_ov, n_ov;
    logic                             r_hit, n_hit;
    logic [tos_pkg::Q_BITS-1:0]       r_score, n_score;
    logic [tos_pkg::Q_BITS-1:0]       r_mean, n_mean;

    // Output register: parts the sequencer from the downstream stall
    tos_pkg::t_out_word               r_out_word, n_out_word;
    logic                             r_out_valid, n_out_valid;

    tos_pkg::t_mul_req                mul_inter_req, mul_truth_req, mul_track_req;
    tos_pkg::t_mul_rsp                mul_inter_rsp, mul_truth_rsp, mul_track_rsp;
    tos_pkg::t_div_req                div_req;
    tos_pkg::t_div_rsp                div_rsp;

    logic                             mul_done;
    logic                             out_free;
    logic [tos_pkg::COORD_BITS-1:0]   span_x, span_y;
    logic [tos_pkg::Q_BITS-1:0]       ov_now;
    logic                             hit_now;
    logic [tos_pkg::TOTAL_BITS:0]     total_sum;

    // Overlap of spans [a0, a0 + al) and [b0, b0 + bl); zero when disjoint or touching
    function automatic logic [tos_pkg::COORD_BITS-1:0] span_len(
        input logic [tos_pkg::COORD_BITS-1:0] a0,
        input logic [tos_pkg::COORD_BITS-1:0] al,
        input logic [tos_pkg::COORD_BITS-1:0] b0,
        input logic [tos_pkg::COORD_BITS-1:0] bl
    );
        logic [tos_pkg::COORD_BITS:0] lo;
        logic [tos_pkg::COORD_BITS:0] ae;
        logic [tos_pkg::COORD_BITS:0] be;
        logic [tos_pkg::COORD_BITS:0] hi;
        logic [tos_pkg::COORD_BITS:0] len;
        lo  = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        ae  = {1'b0, a0} + {1'b0, al};
        be  = {1'b0, b0} + {1'b0, bl};
        hi  = (ae < be) ? ae : be;
        len = (hi > lo) ? (hi - lo) : '0;
        return len[tos_pkg::COORD_BITS-1:0];
    endfunction

    assign span_x   = span_len(r_in.truth_x, r_in.truth_w, r_in.out_x, r_in.out_w);
    assign span_y   = span_len(r_in.truth_y, r_in.truth_h, r_in.out_y, r_in.out_h);
    assign mul_done = mul_inter_rsp.done & mul_truth_rsp.done & mul_track_rsp.done;
    assign out_free = !r_out_valid || !i_out_stall;

    // Overlap is zero without a tracker box or with an empty union
    assign ov_now    = (!r_in.has_output || (r_uni == '0)) ? '0 : div_rsp.quot;
    assign hit_now   = ov_now >= r_thr;
    assign total_sum = {1'b0, r_total}
                     + {{(tos_pkg::TOTAL_BITS + 1 - tos_pkg::Q_BITS){1'b0}}, ov_now};

    // Areas and intersection, one multiplier bit a cycle, all three side by side
    tos_mul u_mul_inter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_inter_req),
        .o_rsp   (mul_inter_rsp)
    );

    tos_mul u_mul_truth (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_truth_req),
        .o_rsp   (mul_truth_rsp)
    );

    tos_mul u_mul_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_track_req),
        .o_rsp   (mul_track_rsp)
    );

    // One divider shared by the overlap, the hit score and the mean overlap
    tos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tos_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = tos_pkg::S_SPAN;
                end
            end
            tos_pkg::S_SPAN: begin
                n_state = tos_pkg::S_MUL;
            end
            tos_pkg::S_MUL: begin
                if (mul_done) begin
                    n_state = tos_pkg::S_UNION;
                end
            end
            tos_pkg::S_UNION: begin
                n_state = tos_pkg::S_IOU_GO;
            end
            tos_pkg::S_IOU_GO: begin
                n_state = tos_pkg::S_IOU;
            end
            tos_pkg::S_IOU: begin
                if (div_rsp.done) begin
                    n_state = tos_pkg::S_TALLY;
                end
            end
            tos_pkg::S_TALLY: begin
                n_state = r_in.run_end ? tos_pkg::S_SCORE_GO : tos_pkg::S_WAIT;
            end
            tos_pkg::S_SCORE_GO: begin
                n_state = tos_pkg::S_SCORE;
            end
            tos_pkg::S_SCORE: begin
                if (div_rsp.done) begin
                    n_state = tos_pkg::S_MEAN_GO;
                end
            end
            tos_pkg::S_MEAN_GO: begin
                n_state = tos_pkg::S_MEAN;
            end
            tos_pkg::S_MEAN: begin
                if (div_rsp.done) begin
                    n_state = tos_pkg::S_WAIT;
                end
            end
            tos_pkg::S_WAIT: begin
                if (out_free) begin
                    n_state = tos_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tos_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: unit requests and the input stall
    always_comb begin
        o_in_stall          = (r_state != tos_pkg::S_IDLE);
        mul_inter_req.start = (r_state == tos_pkg::S_SPAN);
        mul_inter_req.a     = span_x;
        mul_inter_req.b     = span_y;
        mul_truth_req.start = (r_state == tos_pkg::S_SPAN);
        mul_truth_req.a     = r_in.truth_w;
        mul_truth_req.b     = r_in.truth_h;
        mul_track_req.start = (r_state == tos_pkg::S_SPAN);
        mul_track_req.a     = r_in.out_w;
        mul_track_req.b     = r_in.out_h;

        // intersection << FRAC_BITS over the union; the high part is below the union
        div_req.start  = 1'b0;
        div_req.num_hi = {{(tos_pkg::DIV_BITS - tos_pkg::AREA_BITS + 1){1'b0}},
                          mul_inter_rsp.prod[tos_pkg::AREA_BITS-1:1]};
        div_req.num_lo = {mul_inter_rsp.prod[0], {tos_pkg::FRAC_BITS{1'b0}}};
        div_req.den    = r_uni;
        case (r_state)
            tos_pkg::S_IOU_GO: begin
                div_req.start = 1'b1;
            end
            tos_pkg::S_SCORE_GO: begin
                div_req.start  = 1'b1;
                div_req.num_hi = {{(tos_pkg::DIV_BITS - tos_pkg::COUNT_BITS + 1){1'b0}},
                                  r_hits[tos_pkg::COUNT_BITS-1:1]};
                div_req.num_lo = {r_hits[0], {tos_pkg::FRAC_BITS{1'b0}}};
                div_req.den    = {{(tos_pkg::DIV_BITS - tos_pkg::COUNT_BITS){1'b0}}, r_frames};
            end
            tos_pkg::S_MEAN_GO: begin
                div_req.start  = 1'b1;
                div_req.num_hi = {{(tos_pkg::DIV_BITS - tos_pkg::COUNT_BITS){1'b0}},
                                  r_total[tos_pkg::TOTAL_BITS-1:tos_pkg::Q_BITS]};
                div_req.num_lo = r_total[tos_pkg::Q_BITS-1:0];
                div_req.den    = {{(tos_pkg::DIV_BITS - tos_pkg::COUNT_BITS){1'b0}}, r_frames};
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        n_in        = r_in;
        n_thr       = r_thr;
        n_frames    = r_frames;
        n_hits      = r_hits;
        n_total     = r_total;
        n_uni       = r_uni;
        n_ov        = r_ov;
        n_hit       = r_hit;
        n_score     = r_score;
        n_mean      = r_mean;
        n_out_word  = r_out_word;
        n_out_valid = r_out_valid && i_out_stall;

        if (i_cfg_wr_en) begin
            n_thr = i_cfg_wr_data;
        end

        case (r_state)
            tos_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_in = i_in_word;
                end
            end
            tos_pkg::S_UNION: begin
                // intersection never exceeds either area, so no borrow
                n_uni = {1'b0, mul_truth_rsp.prod} + {1'b0, mul_track_rsp.prod}
                      - {1'b0, mul_inter_rsp.prod};
            end
            tos_pkg::S_TALLY: begin
                n_ov  = ov_now;
                n_hit = hit_now;
                if (r_frames != tos_pkg::COUNT_MAX) begin
                    n_frames = r_frames + 1'b1;
                end
                if (hit_now && (r_hits != tos_pkg::COUNT_MAX)) begin
                    n_hits = r_hits + 1'b1;
                end
                n_total = total_sum[tos_pkg::TOTAL_BITS] ? tos_pkg::TOTAL_MAX
                                                         : total_sum[tos_pkg::TOTAL_BITS-1:0];
                // summary fields read zero except on a run's last frame
                n_score = '0;
                n_mean  = '0;
            end
            tos_pkg::S_SCORE: begin
                if (div_rsp.done) begin
                    n_score = div_rsp.quot;
                end
            end
            tos_pkg::S_MEAN: begin
                if (div_rsp.done) begin
                    n_mean = div_rsp.quot;
                end
            end
            tos_pkg::S_WAIT: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_word.overlap       = r_ov;
                    n_out_word.hit           = r_hit;
                    n_out_word.frames_seen   = r_frames;
                    n_out_word.hits_seen     = r_hits;
                    n_out_word.run_done      = r_in.run_end;
                    n_out_word.hit_score     = r_score;
                    n_out_word.mean_overlap  = r_mean;
                    // drop the tallies once the run summary has left
                    if (r_in.run_end) begin
                        n_frames = '0;
                        n_hits   = '0;
                        n_total  = '0;
                    end
                end
            end
            default: begin
                n_in = r_in;
            end
        endcase
    end

    // Control state and tallies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tos_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_thr       <= tos_pkg::THRESH_RESET;
            r_frames    <= '0;
            r_hits      <= '0;
            r_total     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_thr       <= n_thr;
            r_frames    <= n_frames;
            r_hits      <= n_hits;
            r_total     <= n_total;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_in       <= n_in;
        r_uni      <= n_uni;
        r_ov       <= n_ov;
        r_hit      <= n_hit;
        r_score    <= n_score;
        r_mean     <= n_mean;
        r_out_word <= n_out_word;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    // Hits only ever count alongside a frame
    a_hits_le_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hits <= r_frames)
        else $error("hit tally above frame tally");

    // Summary fields stay zero away from a run's last frame
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_word.run_done)
            |-> (o_out_word.hit_score == '0 && o_out_word.mean_overlap == '0))
        else $error("summary field set outside run end");

    // Every result word counts at least its own frame
    a_frames_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.frames_seen != '0))
        else $error("result word with zero frame count");

    // The divider only finishes while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == tos_pkg::S_IOU || r_state == tos_pkg::S_SCORE
                          || r_state == tos_pkg::S_MEAN))
        else $error("divider finished outside a waiting state");
`endif

endmodule
